[sv/bae_pkg.sv]
// Shared constants, types and character helpers for the bare ampersand escaper.
`timescale 1ns / 1ps
`default_nettype none

package bae_pkg;

   localparam int HOLD_DEPTH = 16;
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
   localparam int ADDR_W     = $clog2(HOLD_DEPTH);
   localparam int IDX_W      = (CNT_W > 3) ? CNT_W : 3;

   // Index of the final byte of "&amp;".
   localparam logic [IDX_W-1:0] ESC_LAST = IDX_W'(4);

   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LX     = 8'h78;
   localparam logic [7:0] CH_UX     = 8'h58;
   localparam logic [7:0] CH_USCORE = 8'h5F;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LM     = 8'h6D;
   localparam logic [7:0] CH_LP     = 8'h70;

   typedef enum logic [4:0] {
      PH_IDLE = 5'b00001,
      PH_AMP  = 5'b00010,
      PH_HASH = 5'b00100,
      PH_HEX  = 5'b01000,
      PH_NAME = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      PRE_NONE = 2'd0,
      PRE_AMP  = 2'd1,
      PRE_ESC  = 2'd2
   } pre_type;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_BYTE = 2'd1,
      TAIL_ESC  = 2'd2
   } tail_type;

   // Output plan for one transaction: prefix, held bytes, tail.
   typedef struct packed {
      pre_type          pre;
      logic [CNT_W-1:0] nheld;
      tail_type         tail;
      logic [7:0]       data;
      logic             last;
   } plan_type;

   // Check state update for one transaction.
   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] count;
      logic             wr_en;
   } ctx_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_name(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c == CH_USCORE);
   endfunction

   function automatic logic [7:0] esc_char(input logic [IDX_W-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         IDX_W'(0): c = CH_AMP;
         IDX_W'(1): c = CH_LA;
         IDX_W'(2): c = CH_LM;
         IDX_W'(3): c = CH_LP;
         default:   c = CH_SEMI;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[sv/bae_hold.sv]
// Generic single-port-write RAM with registered read; holds the lookahead bytes.
`timescale 1ns / 1ps
`default_nettype none

module bae_hold #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bae_plan.sv]
// Reference classifier: turns one input byte into an output plan and a state update.
`timescale 1ns / 1ps
`default_nettype none

module bae_plan
   import bae_pkg::*;
(
   input  wire phase_type        phase,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_last,
   output plan_type              plan,
   output ctx_type               ctx
);

   always_comb begin
      logic      hold;
      logic      done;
      logic      fresh_amp;
      phase_type next_ph;

      hold    = 1'b0;
      done    = 1'b0;
      next_ph = PH_IDLE;
      unique case (phase)
         PH_AMP: begin
            if (in_byte == CH_HASH) begin
               hold = 1'b1; next_ph = PH_HASH;
            end else if (is_name(in_byte)) begin
               hold = 1'b1; next_ph = PH_NAME;
            end
         end
         PH_HASH: begin
            if (in_byte == CH_LX || in_byte == CH_UX || is_hex(in_byte)) begin
               hold = 1'b1; next_ph = PH_HEX;
            end else if (in_byte == CH_SEMI) begin
               done = 1'b1;
            end
         end
         PH_HEX: begin
            if (is_hex(in_byte)) begin
               hold = 1'b1; next_ph = PH_HEX;
            end else if (in_byte == CH_SEMI) begin
               done = 1'b1;
            end
         end
         PH_NAME: begin
            if (is_name(in_byte)) begin
               hold = 1'b1; next_ph = PH_NAME;
            end else if (in_byte == CH_SEMI) begin
               done = 1'b1;
            end
         end
         default: ;
      endcase

      fresh_amp  = (in_byte == CH_AMP);
      plan.pre   = PRE_NONE;
      plan.nheld = '0;
      plan.tail  = TAIL_NONE;
      plan.data  = in_byte;
      plan.last  = in_last;
      ctx.phase  = PH_IDLE;
      ctx.count  = '0;
      ctx.wr_en  = 1'b0;

      if (phase == PH_IDLE) begin
         if (fresh_amp) begin
            if (in_last) plan.tail = TAIL_ESC;
            else         ctx.phase = PH_AMP;
         end else begin
            plan.tail = TAIL_BYTE;
         end
      end else if (hold) begin
         if (count == CNT_W'(HOLD_DEPTH)) begin
            // Lookahead too long: treat the ampersand as bare.
            plan.pre   = PRE_ESC;
            plan.nheld = count;
            plan.tail  = TAIL_BYTE;
         end else begin
            ctx.wr_en = 1'b1;
            ctx.phase = next_ph;
            ctx.count = CNT_W'(count + 1'b1);
            if (in_last) begin
               plan.pre   = PRE_ESC;
               plan.nheld = CNT_W'(count + 1'b1);
            end
         end
      end else if (done) begin
         plan.pre   = PRE_AMP;
         plan.nheld = count;
         plan.tail  = TAIL_BYTE;
      end else begin
         plan.pre   = PRE_ESC;
         plan.nheld = count;
         if (fresh_amp) begin
            if (in_last) plan.tail = TAIL_ESC;
            else         ctx.phase = PH_AMP;
         end else begin
            plan.tail = TAIL_BYTE;
         end
      end

      if (in_last) begin
         ctx.phase = PH_IDLE;
         ctx.count = '0;
      end
   end

endmodule

`default_nettype wire

[sv/bare_ampersand_escaper.sv]
// Top level of the bare ampersand escaper: check state, output sequencer, result register.
//
// Usage:
//   req_ channel carries one text byte per transaction (req_in_byte) and a
//   stream end flag (req_in_last). rsp_ channel carries one escaped byte per
//   transaction, with rsp_run_last on the final byte caused by a request and
//   rsp_stream_end on the final byte of the stream.
//   A request is classified in the cycle it is accepted; its output plan
//   (prefix "&" or "&amp;", held bytes, tail byte or "&amp;") is then played
//   out by a sequencer, one byte per cycle while the receiver keeps up,
//   through a single step counter, into the result register. req_ready is
//   high only while the sequencer is idle, so a request that produces bytes
//   blocks the next one until its plan is played out; a request that only
//   extends a pending check produces nothing and the next one may follow in
//   the next cycle. Worst case is HOLD_DEPTH + 10 bytes for one request.
//   A stalled receiver holds the result register and freezes the sequencer;
//   nothing is dropped. Synchronous reset returns the check to idle with an
//   empty hold buffer and clears the result valid; held bytes are never
//   played back before being written.
`timescale 1ns / 1ps
`default_nettype none

module bare_ampersand_escaper
   import bae_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_run_last,
   output logic            rsp_stream_end
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PRE  = 4'b0010,
      S_HELD = 4'b0100,
      S_TAIL = 4'b1000
   } seq_type;

   // Check state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Sequencer
   seq_type          seq_ff, seq_in, seq_start, seq_after;
   logic [IDX_W-1:0] idx_ff, idx_in;
   plan_type         plan_ff, plan_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_run_last_ff;
   logic             rsp_end_ff;

   plan_type         plan;
   ctx_type          ctx;
   logic             accept;
   logic             out_free;
   logic             step;
   logic             seg_end;
   logic             plan_done;
   logic [7:0]       cur_byte;
   logic [7:0]       rd_data;
   logic [IDX_W-1:0] nheld_ext;

   assign req_ready = (seq_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = (seq_ff != S_IDLE) && out_free;
   assign nheld_ext = IDX_W'(plan_ff.nheld);

   bae_plan u_plan (
      .phase   (phase_ff),
      .count   (count_ff),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .plan    (plan),
      .ctx     (ctx)
   );

   // Write the extending byte at the current fill level. Address the read
   // with the next index so the registered data lines up with idx_ff; every
   // plan with held bytes opens with a prefix, so a byte written at accept
   // is in place before playback reads it.
   bae_hold #(
      .WIDTH (8),
      .DEPTH (HOLD_DEPTH)
   ) u_hold (
      .clock   (clock),
      .wr_en   (accept && ctx.wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_in_byte),
      .rd_addr (idx_in[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Pick the first segment of a fresh plan.
   always_comb begin
      if (plan.pre != PRE_NONE)       seq_start = S_PRE;
      else if (plan.nheld != '0)      seq_start = S_HELD;
      else if (plan.tail != TAIL_NONE) seq_start = S_TAIL;
      else                            seq_start = S_IDLE;
   end

   // Current byte and segment end for the running plan.
   always_comb begin
      cur_byte = esc_char(idx_ff);
      seg_end  = 1'b0;
      unique case (seq_ff)
         S_PRE: begin
            if (plan_ff.pre == PRE_AMP) cur_byte = CH_AMP;
            seg_end = (plan_ff.pre == PRE_AMP) || (idx_ff == ESC_LAST);
         end
         S_HELD: begin
            cur_byte = rd_data;
            seg_end  = (IDX_W'(idx_ff + 1'b1) == nheld_ext);
         end
         S_TAIL: begin
            if (plan_ff.tail == TAIL_BYTE) cur_byte = plan_ff.data;
            seg_end = (plan_ff.tail == TAIL_BYTE) || (idx_ff == ESC_LAST);
         end
         default: ;
      endcase
   end

   // Segment that follows the current one.
   always_comb begin
      unique case (seq_ff)
         S_PRE: begin
            if (plan_ff.nheld != '0)           seq_after = S_HELD;
            else if (plan_ff.tail != TAIL_NONE) seq_after = S_TAIL;
            else                               seq_after = S_IDLE;
         end
         S_HELD: begin
            seq_after = (plan_ff.tail != TAIL_NONE) ? S_TAIL : S_IDLE;
         end
         default: seq_after = S_IDLE;
      endcase
   end

   assign plan_done = seg_end && (seq_after == S_IDLE);

   // Next-state selection: accept loads a plan, a step advances it.
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      plan_in      = plan_ff;
      if (accept) begin
         phase_in = ctx.phase;
         count_in = ctx.count;
         seq_in   = seq_start;
         idx_in   = '0;
         plan_in  = plan;
      end else if (step) begin
         seq_in = seg_end ? seq_after : seq_ff;
         idx_in = seg_end ? '0 : IDX_W'(idx_ff + 1'b1);
      end

      if (step)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         seq_ff       <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         seq_ff       <= seq_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: plan and result byte carry no reset.
   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (step) begin
         rsp_byte_ff     <= cur_byte;
         rsp_run_last_ff <= plan_done;
         rsp_end_ff      <= plan_done && plan_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_stream_end = rsp_end_ff;

   // The hold buffer never fills past its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HOLD_DEPTH))
      else $error("hold count exceeds depth");

   // End of stream leaves no check pending.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_in_last |=> (phase_ff == PH_IDLE) && (count_ff == '0))
      else $error("check pending after stream end");

   // Held playback stays inside the plan's byte count.
   a_held_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff == S_HELD |-> idx_ff < nheld_ext)
      else $error("held index out of range");

   // A stream end marker only appears on the last byte of a request.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_end_ff |-> rsp_run_last_ff)
      else $error("stream end without run last");

endmodule

`default_nettype wire
